// ===== hdl/source_text_tokenizer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the source text tokenizer
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define STT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An antecedent that implies a consequent at the same clock edge.
`define STT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Token codes, scan modes, keyword table and the token bundle type.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int KEYWORD_CHARS_DEF = 6;
    localparam int LENGTH_WIDTH_DEF  = 16;
    localparam int LINE_WIDTH_DEF    = 16;

    localparam int MAX_TOKENS  = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int KW_COUNT    = 16;
    localparam int KW_BYTES    = 6;

    localparam logic [5:0] TOK_LEFT_PAREN  = 6'd0;
    localparam logic [5:0] TOK_RIGHT_PAREN = 6'd1;
    localparam logic [5:0] TOK_LEFT_BRACE  = 6'd2;
    localparam logic [5:0] TOK_RIGHT_BRACE = 6'd3;
    localparam logic [5:0] TOK_COMMA       = 6'd4;
    localparam logic [5:0] TOK_DOT         = 6'd5;
    localparam logic [5:0] TOK_MINUS       = 6'd6;
    localparam logic [5:0] TOK_PLUS        = 6'd7;
    localparam logic [5:0] TOK_SEMICOLON   = 6'd8;
    localparam logic [5:0] TOK_SLASH       = 6'd9;
    localparam logic [5:0] TOK_STAR        = 6'd10;
    localparam logic [5:0] TOK_BANG        = 6'd11;
    localparam logic [5:0] TOK_BANG_EQUAL  = 6'd12;
    localparam logic [5:0] TOK_EQUAL       = 6'd13;
    localparam logic [5:0] TOK_EQUAL_EQUAL = 6'd14;
    localparam logic [5:0] TOK_GREATER     = 6'd15;
    localparam logic [5:0] TOK_GREATER_EQ  = 6'd16;
    localparam logic [5:0] TOK_LESS        = 6'd17;
    localparam logic [5:0] TOK_LESS_EQUAL  = 6'd18;
    localparam logic [5:0] TOK_QUESTION    = 6'd19;
    localparam logic [5:0] TOK_COLON       = 6'd20;
    localparam logic [5:0] TOK_IDENTIFIER  = 6'd21;
    localparam logic [5:0] TOK_STRING      = 6'd22;
    localparam logic [5:0] TOK_NUMBER      = 6'd23;
    localparam logic [5:0] TOK_ERROR       = 6'd40;
    localparam logic [5:0] TOK_EOF         = 6'd41;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_GREATER = 8'h3E;

    typedef enum logic [10:0] {
        MODE_IDLE    = 11'b000_0000_0001,
        MODE_BANG    = 11'b000_0000_0010,
        MODE_EQ      = 11'b000_0000_0100,
        MODE_LT      = 11'b000_0000_1000,
        MODE_GT      = 11'b000_0001_0000,
        MODE_IDENT   = 11'b000_0010_0000,
        MODE_INT     = 11'b000_0100_0000,
        MODE_DOT     = 11'b000_1000_0000,
        MODE_FRAC    = 11'b001_0000_0000,
        MODE_STRING  = 11'b010_0000_0000,
        MODE_COMMENT = 11'b100_0000_0000
    } mode_t;

    // Keyword text is right-justified: the first character sits in the
    // highest occupied byte.
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'("and"), 48'("class"), 48'("else"), 48'("false"),
        48'("for"), 48'("func"), 48'("if"), 48'("nil"),
        48'("or"), 48'("print"), 48'("return"), 48'("super"),
        48'("this"), 48'("true"), 48'("var"), 48'("while")
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd4, 3'd2, 3'd3,
        3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
    };

    typedef struct packed {
        logic [1:0]                   count;
        logic [MAX_TOKENS-1:0][5:0]   kind;
        logic [MAX_TOKENS-1:0][31:0]  start;
        logic [MAX_TOKENS-1:0][15:0]  length;
        logic [15:0]                  line;
    } bundle_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Single-character punctuation: returns {hit, kind}.
    function automatic logic [6:0] punct_kind(input logic [7:0] c);
        logic [6:0] r;
        case (c)
            8'h28:   r = {1'b1, TOK_LEFT_PAREN};
            8'h29:   r = {1'b1, TOK_RIGHT_PAREN};
            8'h7B:   r = {1'b1, TOK_LEFT_BRACE};
            8'h7D:   r = {1'b1, TOK_RIGHT_BRACE};
            8'h2C:   r = {1'b1, TOK_COMMA};
            8'h2E:   r = {1'b1, TOK_DOT};
            8'h2D:   r = {1'b1, TOK_MINUS};
            8'h2B:   r = {1'b1, TOK_PLUS};
            8'h3B:   r = {1'b1, TOK_SEMICOLON};
            8'h2F:   r = {1'b1, TOK_SLASH};
            8'h2A:   r = {1'b1, TOK_STAR};
            8'h3F:   r = {1'b1, TOK_QUESTION};
            8'h3A:   r = {1'b1, TOK_COLON};
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    // prefix holds the word's first characters, the first one in the low byte.
    // len of zero or seven matches nothing.
    function automatic logic [5:0] keyword_kind(input logic [47:0] prefix,
                                                input logic [2:0] len);
        logic [5:0] r;
        logic       hit;
        int         k;
        int         i;
        r = TOK_IDENTIFIER;
        for (k = 0; k < KW_COUNT; k++) begin
            hit = (KW_LEN[k] == len);
            for (i = 0; i < KW_BYTES; i++) begin
                if (i < int'(KW_LEN[k])) begin
                    if (prefix[8*i +: 8] != KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8])
                    begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit) begin
                r = 6'(24 + k);
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/stt_if.sv =====
// ----------------------------------------------------------------------------
// Tokenizer channel interfaces
// Valid/ready channels for source bytes in and tokens out.
// ----------------------------------------------------------------------------
interface stt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface stt_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  tok_kind;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;

    modport source (output valid, output tok_kind, output start_offset,
                    output token_length, output line_number, output last_of_run,
                    input ready);
    modport sink   (input valid, input tok_kind, input start_offset,
                    input token_length, input line_number, input last_of_run,
                    output ready);
endinterface

// ===== hdl/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer
// Streaming lexical scanner: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// Channel   Direction  Item
// in_ch     in         data_byte, end_of_input
// out_ch    out        tok_kind, start_offset, token_length, line_number,
//                      last_of_run
//
// The scanner takes one byte every clock while the bundle queue has room.
// An item yields zero to three tokens; the output side sends one token a clock while out_ch is ready.
// Sustained rate is one item per clock while items average one token or less and out_ch stays ready.
// A four-entry bundle queue parts the scanner from the output port.
// Reset is asynchronous and returns the scanner to line one, offset zero.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
    parameter int KEYWORD_CHARS = stt_pkg::KEYWORD_CHARS_DEF,
    parameter int LENGTH_WIDTH  = stt_pkg::LENGTH_WIDTH_DEF,
    parameter int LINE_WIDTH    = stt_pkg::LINE_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    stt_in_if.sink     in_ch,
    stt_out_if.source  out_ch
);

    logic             q_full;
    logic             q_empty;
    logic             push;
    logic             pop;
    stt_pkg::bundle_t push_bundle;
    stt_pkg::bundle_t head;

    stt_front #(
        .KEYWORD_CHARS (KEYWORD_CHARS),
        .LENGTH_WIDTH  (LENGTH_WIDTH),
        .LINE_WIDTH    (LINE_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .q_full      (q_full),
        .push        (push),
        .push_bundle (push_bundle)
    );

    stt_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .pop         (pop),
        .full        (q_full),
        .empty       (q_empty),
        .head        (head)
    );

    stt_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (q_empty),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

// ===== hdl/stt_front.sv =====
// ----------------------------------------------------------------------------
// Tokenizer front end
// Scans one byte per item and forms the bundle of tokens that it completes.
// ----------------------------------------------------------------------------
module stt_front #(
    parameter int KEYWORD_CHARS = stt_pkg::KEYWORD_CHARS_DEF,
    parameter int LENGTH_WIDTH  = stt_pkg::LENGTH_WIDTH_DEF,
    parameter int LINE_WIDTH    = stt_pkg::LINE_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    stt_in_if.sink           in_ch,
    input  logic             q_full,
    output logic             push,
    output stt_pkg::bundle_t push_bundle
);

    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX  = '1;
    localparam logic [LINE_WIDTH-1:0]   LINE_MAX = '1;

    stt_pkg::mode_t                   mode_reg, mode_next;
    logic [31:0]                      start_reg, start_next;
    logic [31:0]                      pos_reg, pos_next;
    logic [LENGTH_WIDTH-1:0]          len_reg, len_next;
    logic [LINE_WIDTH-1:0]            line_reg, line_next;
    logic [KEYWORD_CHARS-1:0][7:0]    prefix_reg, prefix_next;
    logic                             halt_reg, halt_next;

    logic                             accept;
    logic [7:0]                       c;
    logic [LENGTH_WIDTH-1:0]          len_inc1, len_inc2;
    logic [LINE_WIDTH-1:0]            line_inc;
    logic [5:0]                       word_kind;
    logic [2:0]                       kw_len;
    logic [6:0]                       punct;
    logic [5:0]                       op_kind;
    logic                             do_flush, do_idle, do_eof;
    logic [1:0]                       n;
    stt_pkg::bundle_t                 b;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;
    assign c           = in_ch.data_byte;

    assign len_inc1 = (len_reg == LEN_MAX) ? LEN_MAX : len_reg + LENGTH_WIDTH'(1);
    assign len_inc2 = (len_reg >= LEN_MAX - LENGTH_WIDTH'(1)) ? LEN_MAX
                                                              : len_reg + LENGTH_WIDTH'(2);
    assign line_inc = (line_reg == LINE_MAX) ? LINE_MAX : line_reg + LINE_WIDTH'(1);

    assign kw_len    = (len_reg <= LENGTH_WIDTH'(stt_pkg::KW_BYTES)) ? 3'(len_reg) : 3'd7;
    assign word_kind = stt_pkg::keyword_kind(prefix_reg[stt_pkg::KW_BYTES-1:0], kw_len);
    assign punct     = stt_pkg::punct_kind(c);

    always_comb
    begin
        case (mode_reg)
            stt_pkg::MODE_BANG: op_kind = stt_pkg::TOK_BANG;
            stt_pkg::MODE_EQ:   op_kind = stt_pkg::TOK_EQUAL;
            stt_pkg::MODE_LT:   op_kind = stt_pkg::TOK_LESS;
            default:            op_kind = stt_pkg::TOK_GREATER;
        endcase
    end

    always_comb
    begin
        mode_next   = mode_reg;
        start_next  = start_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        line_next   = line_reg;
        prefix_next = prefix_reg;
        halt_next   = halt_reg;
        do_flush    = 1'b0;
        do_idle     = 1'b0;
        do_eof      = 1'b0;
        n           = 2'd0;
        b           = '0;
        b.line      = 16'(line_reg);

        if (accept && !halt_reg) begin
            if (in_ch.end_of_input) begin
                do_eof = 1'b1;
                if (mode_reg == stt_pkg::MODE_STRING) begin
                    b.kind[n]   = stt_pkg::TOK_ERROR;
                    b.start[n]  = start_reg;
                    b.length[n] = 16'(len_reg);
                    n           = n + 2'd1;
                    halt_next   = 1'b1;
                end else begin
                    do_flush = 1'b1;
                end
            end else begin
                pos_next = pos_reg + 32'd1;
                case (mode_reg)
                    stt_pkg::MODE_IDENT:
                    begin
                        if (stt_pkg::is_letter(c) || stt_pkg::is_decimal(c)) begin
                            for (int i = 0; i < KEYWORD_CHARS; i++) begin
                                if (len_reg == LENGTH_WIDTH'(i)) begin
                                    prefix_next[i] = c;
                                end
                            end
                            len_next = len_inc1;
                        end else begin
                            do_flush = 1'b1;
                            do_idle  = 1'b1;
                        end
                    end
                    stt_pkg::MODE_INT:
                    begin
                        if (stt_pkg::is_decimal(c)) begin
                            len_next = len_inc1;
                        end else if (c == stt_pkg::CH_DOT) begin
                            mode_next = stt_pkg::MODE_DOT;
                        end else begin
                            do_flush = 1'b1;
                            do_idle  = 1'b1;
                        end
                    end
                    stt_pkg::MODE_DOT:
                    begin
                        if (stt_pkg::is_decimal(c)) begin
                            len_next  = len_inc2;
                            mode_next = stt_pkg::MODE_FRAC;
                        end else begin
                            do_flush = 1'b1;
                            do_idle  = 1'b1;
                        end
                    end
                    stt_pkg::MODE_FRAC:
                    begin
                        if (stt_pkg::is_decimal(c)) begin
                            len_next = len_inc1;
                        end else begin
                            do_flush = 1'b1;
                            do_idle  = 1'b1;
                        end
                    end
                    stt_pkg::MODE_BANG, stt_pkg::MODE_EQ, stt_pkg::MODE_LT,
                    stt_pkg::MODE_GT:
                    begin
                        if (c == stt_pkg::CH_EQUAL) begin
                            b.kind[n]   = op_kind + 6'd1;
                            b.start[n]  = start_reg;
                            b.length[n] = 16'd2;
                            n           = n + 2'd1;
                            mode_next   = stt_pkg::MODE_IDLE;
                        end else begin
                            do_flush = 1'b1;
                            do_idle  = 1'b1;
                        end
                    end
                    stt_pkg::MODE_STRING:
                    begin
                        len_next = len_inc1;
                        if (c == stt_pkg::CH_QUOTE) begin
                            b.kind[n]   = stt_pkg::TOK_STRING;
                            b.start[n]  = start_reg;
                            b.length[n] = 16'(len_inc1);
                            n           = n + 2'd1;
                            mode_next   = stt_pkg::MODE_IDLE;
                        end else if (c == stt_pkg::CH_LF) begin
                            line_next = line_inc;
                        end
                    end
                    stt_pkg::MODE_COMMENT:
                    begin
                        if (c == stt_pkg::CH_LF) begin
                            do_idle = 1'b1;
                        end
                    end
                    default:
                    begin
                        do_idle = 1'b1;
                    end
                endcase
            end

            // The pending token cannot grow: emit what it has become.
            if (do_flush) begin
                mode_next = stt_pkg::MODE_IDLE;
                case (mode_reg)
                    stt_pkg::MODE_IDENT:
                    begin
                        b.kind[n]   = word_kind;
                        b.start[n]  = start_reg;
                        b.length[n] = 16'(len_reg);
                        n           = n + 2'd1;
                    end
                    stt_pkg::MODE_INT, stt_pkg::MODE_FRAC, stt_pkg::MODE_DOT:
                    begin
                        b.kind[n]   = stt_pkg::TOK_NUMBER;
                        b.start[n]  = start_reg;
                        b.length[n] = 16'(len_reg);
                        n           = n + 2'd1;
                        if (mode_reg == stt_pkg::MODE_DOT) begin
                            b.kind[n]   = stt_pkg::TOK_DOT;
                            b.start[n]  = pos_reg - 32'd1;
                            b.length[n] = 16'd1;
                            n           = n + 2'd1;
                        end
                    end
                    stt_pkg::MODE_BANG, stt_pkg::MODE_EQ, stt_pkg::MODE_LT,
                    stt_pkg::MODE_GT:
                    begin
                        b.kind[n]   = op_kind;
                        b.start[n]  = start_reg;
                        b.length[n] = 16'd1;
                        n           = n + 2'd1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Scan the byte as if between tokens.
            if (do_idle) begin
                mode_next = stt_pkg::MODE_IDLE;
                if (c == stt_pkg::CH_LF) begin
                    line_next = line_inc;
                end else if (stt_pkg::is_letter(c) || stt_pkg::is_decimal(c) ||
                             c == stt_pkg::CH_BANG || c == stt_pkg::CH_EQUAL ||
                             c == stt_pkg::CH_LESS || c == stt_pkg::CH_GREATER ||
                             c == stt_pkg::CH_QUOTE) begin
                    start_next = pos_reg;
                    len_next   = LENGTH_WIDTH'(1);
                    if (stt_pkg::is_letter(c)) begin
                        mode_next      = stt_pkg::MODE_IDENT;
                        prefix_next[0] = c;
                    end else if (stt_pkg::is_decimal(c)) begin
                        mode_next = stt_pkg::MODE_INT;
                    end else if (c == stt_pkg::CH_BANG) begin
                        mode_next = stt_pkg::MODE_BANG;
                    end else if (c == stt_pkg::CH_EQUAL) begin
                        mode_next = stt_pkg::MODE_EQ;
                    end else if (c == stt_pkg::CH_LESS) begin
                        mode_next = stt_pkg::MODE_LT;
                    end else if (c == stt_pkg::CH_GREATER) begin
                        mode_next = stt_pkg::MODE_GT;
                    end else begin
                        mode_next = stt_pkg::MODE_STRING;
                    end
                end else if (c == stt_pkg::CH_HASH) begin
                    mode_next = stt_pkg::MODE_COMMENT;
                end else if (punct[6]) begin
                    b.kind[n]   = punct[5:0];
                    b.start[n]  = pos_reg;
                    b.length[n] = 16'd1;
                    n           = n + 2'd1;
                end
            end

            if (do_eof) begin
                b.kind[n]   = stt_pkg::TOK_EOF;
                b.start[n]  = pos_reg;
                b.length[n] = 16'd0;
                n           = n + 2'd1;
                mode_next   = stt_pkg::MODE_IDLE;
                len_next    = '0;
                if (!halt_next) begin
                    pos_next  = '0;
                    line_next = LINE_WIDTH'(1);
                end
            end
        end
        b.count = n;
    end

    assign push        = accept && !halt_reg && (n != 2'd0);
    assign push_bundle = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= stt_pkg::MODE_IDLE;
            start_reg  <= '0;
            pos_reg    <= '0;
            len_reg    <= '0;
            line_reg   <= LINE_WIDTH'(1);
            prefix_reg <= '0;
            halt_reg   <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            start_reg  <= start_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            line_reg   <= line_next;
            prefix_reg <= prefix_next;
            halt_reg   <= halt_next;
        end
    end

endmodule

// ===== hdl/stt_queue.sv =====
// ----------------------------------------------------------------------------
// Token bundle queue
// Short queue of token bundles between the scanner and the output side.
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_assert.svh"

module stt_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  stt_pkg::bundle_t push_bundle,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output stt_pkg::bundle_t head
);

    stt_pkg::bundle_t                mem_reg [stt_pkg::QUEUE_DEPTH];
    logic [stt_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [stt_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [stt_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;

    assign full  = (cnt_reg == stt_pkg::QCNT_W'(stt_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + stt_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + stt_pkg::QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + stt_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - stt_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_bundle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `STT_ASSERT_IMPLY(a_no_push_full, push, !full, "bundle pushed into a full queue")
    `STT_ASSERT_IMPLY(a_no_pop_empty, pop, !empty, "bundle popped from an empty queue")
    `STT_ASSERT_IMPLY(a_push_nonzero, push, push_bundle.count != 2'd0,
        "bundle pushed without tokens")
    `STT_ASSERT_ALWAYS(a_count_bound, cnt_reg <= stt_pkg::QCNT_W'(stt_pkg::QUEUE_DEPTH),
        "queue occupancy beyond depth")

endmodule

// ===== hdl/stt_back.sv =====
// ----------------------------------------------------------------------------
// Token output stage
// Sends the tokens of the head bundle one item at a time.
// ----------------------------------------------------------------------------
module stt_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  stt_pkg::bundle_t head,
    output logic             pop,
    stt_out_if.source        out_ch
);

    logic [1:0] sub_reg, sub_next;
    logic       last;
    logic       take;

    assign last = (sub_reg == head.count - 2'd1);
    assign take = out_ch.valid && out_ch.ready;
    assign pop  = take && last;

    assign out_ch.valid        = !empty;
    assign out_ch.tok_kind     = head.kind[sub_reg];
    assign out_ch.start_offset = head.start[sub_reg];
    assign out_ch.token_length = head.length[sub_reg];
    assign out_ch.line_number  = head.line;
    assign out_ch.last_of_run  = last;

    always_comb
    begin
        sub_next = sub_reg;
        if (take) begin
            sub_next = last ? 2'd0 : sub_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sub_reg <= 2'd0;
        end else begin
            sub_reg <= sub_next;
        end
    end

endmodule
